// ----- hw/rtl/go_back_n_sender_unit_defines.svh -----
// Assertion macros for the checker file of the Go-Back-N sender.
`ifndef GO_BACK_N_SENDER_UNIT_DEFINES_SVH
`define GO_BACK_N_SENDER_UNIT_DEFINES_SVH

// Clocked assertion with asynchronous active-low reset disable.
`define GBN_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, with the clock and reset fixed to the unit's port names.
`define GBN_ASSERT_CLK(lbl, prop, msg) \
  `GBN_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- hw/rtl/gbn_pkg.sv -----
// Package with constants, codes and item types of the Go-Back-N sender.
`timescale 1ns / 1ps

package gbn_pkg;

  localparam int SeqBits     = 16;
  localparam int MaxWindow   = 64;
  localparam int WinBits     = 7;
  localparam int CountBits   = 16;
  localparam int OpBits      = 2;
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 16;
  localparam int QueueDepth  = 2;
  localparam int QPtrBits    = $clog2(QueueDepth);
  localparam int QCntBits    = $clog2(QueueDepth + 1);

  localparam logic [OpBits-1:0] OP_START   = 2'd0;
  localparam logic [OpBits-1:0] OP_ACK     = 2'd1;
  localparam logic [OpBits-1:0] OP_TIMEOUT = 2'd2;

  localparam logic [CfgIdxBits-1:0] CFG_FRAME_COUNT = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_WINDOW_SIZE = 2'd1;

  localparam logic [CountBits-1:0] FRAME_COUNT_RESET = 16'd8;
  localparam logic [WinBits-1:0]   WINDOW_SIZE_RESET = 7'd4;

  localparam logic [SeqBits-1:0] SEQ_MASK = {SeqBits{1'b1}};

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic [OpBits-1:0]  op;
    logic [SeqBits-1:0] ack_number;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [SeqBits-1:0] seq_number;
    logic               last;
  } out_item_t;

  // Burst command from front to back: an end marker or a run of frames.
  typedef struct packed {
    logic               is_end;
    logic [SeqBits-1:0] first_seq;
    logic [WinBits-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- hw/rtl/gbn_front.sv -----
// Front end: accepts events, keeps window state and issues burst commands.
`timescale 1ns / 1ps

module gbn_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  gbn_pkg::in_item_t                in_item_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [gbn_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [gbn_pkg::CfgDataBits-1:0]  cfg_data_i,
  input  gbn_pkg::q_stat_t                 q_stat_i,
  output logic                             push_o,
  output gbn_pkg::cmd_t                    cmd_o
);

  logic [gbn_pkg::CountBits-1:0] frame_count_q, frame_count_d;
  logic [gbn_pkg::WinBits-1:0]   window_size_q, window_size_d;
  logic [gbn_pkg::SeqBits-1:0]   base_q, base_d, next_q, next_d;
  logic [gbn_pkg::WinBits-1:0]   outs_q, outs_d;
  logic                          active_q, active_d;

  logic                          accept;
  logic [gbn_pkg::SeqBits-1:0]   lim, base_n, next_n, avail;
  logic [gbn_pkg::WinBits-1:0]   win, outs_n, room, n_send;
  logic                          do_end, do_fill;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_stat_i.full;
  assign accept      = in_valid_i && !q_stat_i.full;

  assign lim = gbn_pkg::SeqBits'((32'(frame_count_q) > 32'(gbn_pkg::SEQ_MASK)) ?
               32'(gbn_pkg::SEQ_MASK) : 32'(frame_count_q));
  assign win = (window_size_q > gbn_pkg::WinBits'(gbn_pkg::MaxWindow)) ?
               gbn_pkg::WinBits'(gbn_pkg::MaxWindow) : window_size_q;

  always_comb begin
    base_n   = base_q;
    next_n   = next_q;
    outs_n   = outs_q;
    active_d = active_q;
    do_end   = 1'b0;
    do_fill  = 1'b0;
    if (accept) begin
      if (in_item_i.op == gbn_pkg::OP_START) begin
        base_n   = '0;
        next_n   = '0;
        outs_n   = '0;
        active_d = 1'b1;
        if (lim == '0) begin
          active_d = 1'b0;
          do_end   = 1'b1;
        end else begin
          do_fill = 1'b1;
        end
      end else if (active_q && (in_item_i.op == gbn_pkg::OP_ACK ||
                                in_item_i.op == gbn_pkg::OP_TIMEOUT)) begin
        if (in_item_i.op == gbn_pkg::OP_ACK && in_item_i.ack_number == base_q) begin
          // Slide the window by one.
          outs_n = (outs_q != '0) ? outs_q - 1'b1 : '0;
          base_n = base_q + 1'b1;
          next_n = (next_q < base_n) ? base_n : next_q;
          if (base_n >= lim) begin
            active_d = 1'b0;
            do_end   = 1'b1;
          end else begin
            do_fill = 1'b1;
          end
        end else begin
          // Rewind and resend the window.
          next_n  = base_q;
          outs_n  = '0;
          do_fill = 1'b1;
        end
      end
    end
  end

  assign room   = (win > outs_n) ? win - outs_n : '0;
  assign avail  = (lim > next_n) ? lim - next_n : '0;
  assign n_send = (32'(avail) < 32'(room)) ? gbn_pkg::WinBits'(avail) : room;

  always_comb begin
    base_d = base_n;
    next_d = next_n;
    outs_d = outs_n;
    if (do_fill) begin
      next_d = next_n + gbn_pkg::SeqBits'(n_send);
      outs_d = outs_n + n_send;
    end
  end

  assign push_o          = do_end || (do_fill && n_send != '0);
  assign cmd_o.is_end    = do_end;
  assign cmd_o.first_seq = do_end ? '0 : next_n;
  assign cmd_o.count     = n_send;

  always_comb begin
    frame_count_d = frame_count_q;
    window_size_d = window_size_q;
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == gbn_pkg::CFG_FRAME_COUNT) begin
        frame_count_d = cfg_data_i[gbn_pkg::CountBits-1:0];
      end else if (cfg_index_i == gbn_pkg::CFG_WINDOW_SIZE) begin
        window_size_d = cfg_data_i[gbn_pkg::WinBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= gbn_pkg::FRAME_COUNT_RESET;
      window_size_q <= gbn_pkg::WINDOW_SIZE_RESET;
      base_q        <= '0;
      next_q        <= '0;
      outs_q        <= '0;
      active_q      <= 1'b0;
    end else begin
      frame_count_q <= frame_count_d;
      window_size_q <= window_size_d;
      base_q        <= base_d;
      next_q        <= next_d;
      outs_q        <= outs_d;
      active_q      <= active_d;
    end
  end

endmodule

// ----- hw/rtl/gbn_queue.sv -----
// Short command queue between the front and back ends.
`timescale 1ns / 1ps

module gbn_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  gbn_pkg::cmd_t    data_i,
  input  logic             pop_i,
  output gbn_pkg::cmd_t    data_o,
  output gbn_pkg::q_stat_t stat_o
);

  gbn_pkg::cmd_t                mem_q [gbn_pkg::QueueDepth];
  logic [gbn_pkg::QPtrBits-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [gbn_pkg::QCntBits-1:0] cnt_q, cnt_d;
  logic                         do_push, do_pop;

  assign stat_o.full  = (cnt_q == gbn_pkg::QCntBits'(gbn_pkg::QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == gbn_pkg::QPtrBits'(gbn_pkg::QueueDepth - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == gbn_pkg::QPtrBits'(gbn_pkg::QueueDepth - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ----- hw/rtl/gbn_back.sv -----
// Back end: expands burst commands into registered results, one per cycle while the output is not stalled.
`timescale 1ns / 1ps

module gbn_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gbn_pkg::cmd_t      cmd_i,
  input  gbn_pkg::q_stat_t   q_stat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output gbn_pkg::out_item_t out_item_o
);

  logic [gbn_pkg::SeqBits-1:0] cur_q, cur_d;
  logic [gbn_pkg::WinBits-1:0] rem_q, rem_d;
  logic                        valid_q, valid_d;
  gbn_pkg::out_item_t          item_q, item_d;
  logic                        advance;

  assign advance     = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_comb begin
    cur_d   = cur_q;
    rem_d   = rem_q;
    valid_d = valid_q;
    item_d  = item_q;
    pop_o   = 1'b0;
    if (advance) begin
      if (rem_q != '0) begin
        item_d.kind       = gbn_pkg::KIND_DATA;
        item_d.seq_number = cur_q;
        item_d.last       = (rem_q == gbn_pkg::WinBits'(1));
        valid_d           = 1'b1;
        cur_d             = cur_q + 1'b1;
        rem_d             = rem_q - 1'b1;
      end else if (!q_stat_i.empty) begin
        pop_o   = 1'b1;
        valid_d = 1'b1;
        if (cmd_i.is_end) begin
          item_d.kind       = gbn_pkg::KIND_END;
          item_d.seq_number = '0;
          item_d.last       = 1'b1;
        end else begin
          item_d.kind       = gbn_pkg::KIND_DATA;
          item_d.seq_number = cmd_i.first_seq;
          item_d.last       = (cmd_i.count == gbn_pkg::WinBits'(1));
          cur_d             = cmd_i.first_seq + 1'b1;
          rem_d             = cmd_i.count - 1'b1;
        end
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    cur_q  <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      rem_q   <= rem_d;
      valid_q <= valid_d;
    end
  end

endmodule

// ----- hw/rtl/go_back_n_sender_unit.sv -----
// Go-Back-N sender: top level joining front end, command queue and back end.
// With the queue empty and the output free, an accepted item is written into the command queue,
// and its first result is then registered in the back end's output register.
// One result per cycle while the output is not stalled; an item that sends n frames holds the back end for n results.
// The front takes one item per cycle while the two-entry command queue has room.
// Reset clears window state, the queue and the output valid; frame_count = 8, window_size = 4.
`timescale 1ns / 1ps

module go_back_n_sender_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  gbn_pkg::in_item_t               in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output gbn_pkg::out_item_t              out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gbn_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [gbn_pkg::CfgDataBits-1:0] cfg_data_i
);

  // Front to queue: one command per accepted item that causes results.
  logic             push;
  gbn_pkg::cmd_t    push_cmd;
  // Queue to back: head command and fill status.
  gbn_pkg::cmd_t    head_cmd;
  gbn_pkg::q_stat_t q_stat;
  logic             pop;

  // Classify events, update base / next / outstanding, size the burst.
  gbn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // Decouple the front from a stalled or busy back end.
  gbn_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .pop_i  (pop),
    .data_o (head_cmd),
    .stat_o (q_stat)
  );

  // Emit frames or the end marker of the head command, one per cycle while not stalled, into the output register.
  gbn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- hw/rtl/gbn_checker.sv -----
// Port-level assertions for the Go-Back-N sender and their bind.
`timescale 1ns / 1ps
`include "go_back_n_sender_unit_defines.svh"

module gbn_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input gbn_pkg::out_item_t out_item_o
);

  logic                        out_acc, out_end, out_data, out_mid;
  logic [gbn_pkg::SeqBits-1:0] out_seq, seq_next;

  assign out_acc  = out_valid_o && !out_stall_i;
  assign out_end  = out_valid_o && out_item_o.kind == gbn_pkg::KIND_END;
  assign out_data = out_valid_o && out_item_o.kind == gbn_pkg::KIND_DATA;
  assign out_mid  = out_acc && out_item_o.kind == gbn_pkg::KIND_DATA && !out_item_o.last;
  assign out_seq  = out_item_o.seq_number;
  assign seq_next = out_seq + 1'b1;

  `GBN_ASSERT_CLK(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped")
  `GBN_ASSERT_CLK(a_end_form, out_end |-> out_seq == '0 && out_item_o.last, "bad end marker")
  `GBN_ASSERT_CLK(a_burst_seq, out_mid |=> out_data && out_seq == $past(seq_next), "gap in burst")

endmodule

bind go_back_n_sender_unit gbn_checker u_gbn_checker (.*);
